>>> hdl/pcpm_pkg.sv
// Shared types, constants and codes for the pedal cadence period meter.
// No dependencies; every other file imports this package.
package pcpm_pkg;

    // Timestamp width actually used; the request field stays 32 bits.
    localparam int TICK_BITS    = 32;
    localparam int PERIOD_CLAMP = 64000;
    localparam int PERIOD_FLOOR = 70;

    localparam int NUM_BITS  = 23;
    localparam int STEP_BITS = 8;
    localparam int RPM_BITS  = 16;
    localparam int PER_BITS  = 16;
    localparam int CNT_BITS  = 32;
    localparam int DIV_STEPS = NUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = NUM_BITS;

    localparam logic [STEP_BITS-1:0] SPP_RESET = 8'd1;
    localparam logic [NUM_BITS-1:0]  NUM_RESET = 23'd10000;

    typedef enum logic [1:0] {
        MODE_STEP  = 2'd0,
        MODE_BREAK = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CAUSE_REVERSE = 2'd0,
        CAUSE_INVALID = 2'd1
    } t_cause;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_STEPS_PER_PULSE = 2'd0,
        CFG_RPM_NUMERATOR   = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] tick;
        logic        origin_mark;
        logic [1:0]  cause;
    } t_in_req;

    typedef struct packed {
        logic                pulse;
        logic                measured;
        logic [RPM_BITS-1:0] step_rpm;
        logic [PER_BITS-1:0] step_period;
        logic [RPM_BITS-1:0] held_rpm;
        logic                held_valid;
        logic [PER_BITS-1:0] held_period;
        logic [CNT_BITS-1:0] measurement_count;
        logic [CNT_BITS-1:0] reverse_breaks;
        logic [CNT_BITS-1:0] invalid_breaks;
        logic [CNT_BITS-1:0] overflow_breaks;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic div_done;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_dp_status;

endpackage

>>> hdl/pcpm_ctrl.sv
// Sequencer for the pedal cadence period meter: handshakes and divide timing.
// Depends on pcpm_pkg.
module pcpm_ctrl import pcpm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;
    logic   w_accept;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_accept    = (r_state == S_IDLE) && w_slot_free && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_status.need_div) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = !w_slot_free;
                o_cmd.accept = w_accept;
            end
            S_DIV:   o_cmd.div_step = 1'b1;
            S_DONE:  o_cmd.div_done = 1'b1;
            default: o_in_stall = 1'b1;
        endcase
    end

    // Load the result slot when an item finishes; drain it on a taken request.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if ((w_accept && !i_status.need_div) || (r_state == S_DONE)) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/pcpm_dp.sv
// Datapath for the pedal cadence period meter: measurement state, counters,
// configuration registers, restoring divider and result register. Uses pcpm_pkg.
module pcpm_dp import pcpm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  t_in_req                   i_req,
    input  t_ctrl_cmd                 i_cmd,
    output t_dp_status                o_status,
    output t_result                   o_res
);

    logic [STEP_BITS-1:0] r_spp;
    logic [NUM_BITS-1:0]  r_num;

    logic [RPM_BITS-1:0]  r_rpm_hold,  n_rpm_hold;
    logic                 r_rpm_valid, n_rpm_valid;
    logic                 r_epoch_ok,  n_epoch_ok;
    logic [PER_BITS-1:0]  r_per_hold,  n_per_hold;
    logic [TICK_BITS-1:0] r_origin,    n_origin;
    logic [STEP_BITS-1:0] r_step_cnt,  n_step_cnt;
    logic [CNT_BITS-1:0]  r_acc_cnt,   n_acc_cnt;
    logic [CNT_BITS-1:0]  r_rev_cnt,   n_rev_cnt;
    logic [CNT_BITS-1:0]  r_inv_cnt,   n_inv_cnt;
    logic [CNT_BITS-1:0]  r_ovf_cnt,   n_ovf_cnt;

    // Divider
    logic [PER_BITS-1:0]     r_div_per;
    logic [PER_BITS-1:0]     r_rem;
    logic [NUM_BITS-1:0]     r_quo;
    logic [DIV_CNT_BITS-1:0] r_div_cnt;
    logic [PER_BITS:0]       w_trial;
    logic                    w_fits;

    t_result r_res, n_res;

    logic [STEP_BITS-1:0] w_step_inc;
    logic                 w_reached;
    logic [TICK_BITS-1:0] w_diff;
    logic [PER_BITS-1:0]  w_period;
    logic [RPM_BITS-1:0]  w_rpm;
    logic                 w_is_pulse;

    assign w_step_inc = r_step_cnt + STEP_BITS'(1);
    assign w_reached  = (w_step_inc >= r_spp);
    assign w_diff     = i_req.tick[TICK_BITS-1:0] - r_origin;
    assign w_period   = (w_diff > TICK_BITS'(PERIOD_CLAMP)) ?
                        PER_BITS'(PERIOD_CLAMP) : w_diff[PER_BITS-1:0];
    assign w_is_pulse = (i_req.mode == MODE_STEP) && !i_req.origin_mark && w_reached;

    assign o_status.need_div = w_is_pulse && r_epoch_ok &&
                               (w_period > PER_BITS'(PERIOD_FLOOR));
    assign o_status.div_last = (r_div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign w_trial = {r_rem, r_quo[NUM_BITS-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div_per});

    // Saturate the quotient to the rpm width.
    assign w_rpm = (r_quo > NUM_BITS'(2**RPM_BITS - 1)) ?
                   {RPM_BITS{1'b1}} : r_quo[RPM_BITS-1:0];

    always_comb begin
        n_rpm_hold  = r_rpm_hold;
        n_rpm_valid = r_rpm_valid;
        n_epoch_ok  = r_epoch_ok;
        n_per_hold  = r_per_hold;
        n_origin    = r_origin;
        n_step_cnt  = r_step_cnt;
        n_acc_cnt   = r_acc_cnt;
        n_rev_cnt   = r_rev_cnt;
        n_inv_cnt   = r_inv_cnt;
        n_ovf_cnt   = r_ovf_cnt;
        n_res       = r_res;

        if (i_cmd.accept) begin
            n_res.pulse       = 1'b0;
            n_res.measured    = 1'b0;
            n_res.step_rpm    = '0;
            n_res.step_period = '0;
            case (i_req.mode)
                MODE_STEP: begin
                    if (i_req.origin_mark) begin
                        n_origin   = i_req.tick[TICK_BITS-1:0];
                        n_epoch_ok = 1'b1;
                        n_step_cnt = '0;
                    end else if (w_reached) begin
                        n_res.pulse = 1'b1;
                        if (r_epoch_ok) begin
                            n_res.step_period = w_period;
                        end
                        n_origin   = i_req.tick[TICK_BITS-1:0];
                        n_epoch_ok = 1'b1;
                        n_step_cnt = '0;
                    end else begin
                        n_step_cnt = w_step_inc;
                    end
                end
                MODE_BREAK: begin
                    if (r_epoch_ok) begin
                        case (i_req.cause)
                            CAUSE_REVERSE: n_rev_cnt = r_rev_cnt + CNT_BITS'(1);
                            CAUSE_INVALID: n_inv_cnt = r_inv_cnt + CNT_BITS'(1);
                            default:       n_ovf_cnt = r_ovf_cnt + CNT_BITS'(1);
                        endcase
                    end
                    n_epoch_ok = 1'b0;
                    n_step_cnt = '0;
                end
                MODE_CLEAR: begin
                    n_rpm_hold  = '0;
                    n_rpm_valid = 1'b0;
                    n_epoch_ok  = 1'b0;
                    n_per_hold  = '0;
                    n_origin    = '0;
                    n_step_cnt  = '0;
                end
                default: n_step_cnt = r_step_cnt;
            endcase
        end

        if (i_cmd.div_done) begin
            n_rpm_hold     = w_rpm;
            n_rpm_valid    = 1'b1;
            n_per_hold     = r_div_per;
            n_acc_cnt      = r_acc_cnt + CNT_BITS'(1);
            n_res.measured = 1'b1;
            n_res.step_rpm = w_rpm;
        end

        n_res.held_rpm          = n_rpm_hold;
        n_res.held_valid        = n_rpm_valid;
        n_res.held_period       = n_per_hold;
        n_res.measurement_count = n_acc_cnt;
        n_res.reverse_breaks    = n_rev_cnt;
        n_res.invalid_breaks    = n_inv_cnt;
        n_res.overflow_breaks   = n_ovf_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp       <= SPP_RESET;
            r_num       <= NUM_RESET;
            r_rpm_hold  <= '0;
            r_rpm_valid <= 1'b0;
            r_epoch_ok  <= 1'b0;
            r_per_hold  <= '0;
            r_origin    <= '0;
            r_step_cnt  <= '0;
            r_acc_cnt   <= '0;
            r_rev_cnt   <= '0;
            r_inv_cnt   <= '0;
            r_ovf_cnt   <= '0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STEPS_PER_PULSE: r_spp <= i_cfg_data[STEP_BITS-1:0];
                    CFG_RPM_NUMERATOR:   r_num <= i_cfg_data;
                    default:             r_spp <= r_spp;
                endcase
            end
            r_rpm_hold  <= n_rpm_hold;
            r_rpm_valid <= n_rpm_valid;
            r_epoch_ok  <= n_epoch_ok;
            r_per_hold  <= n_per_hold;
            r_origin    <= n_origin;
            r_step_cnt  <= n_step_cnt;
            r_acc_cnt   <= n_acc_cnt;
            r_rev_cnt   <= n_rev_cnt;
            r_inv_cnt   <= n_inv_cnt;
            r_ovf_cnt   <= n_ovf_cnt;
            if (i_cmd.accept) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_BITS'(1);
            end
        end
    end

    // Payload registers: divider operands and the result slot.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.accept) begin
            r_div_per <= w_period;
            r_rem     <= '0;
            r_quo     <= r_num;
        end else if (i_cmd.div_step) begin
            r_rem <= w_fits ? PER_BITS'(w_trial - {1'b0, r_div_per}) : w_trial[PER_BITS-1:0];
            r_quo <= {r_quo[NUM_BITS-2:0], w_fits};
        end
    end

    assign o_res = r_res;

endmodule

>>> hdl/pedal_cadence_period_meter_unit.sv
// Top level of the pedal cadence period meter: handshake ports, controller
// and datapath. Depends on pcpm_pkg, pcpm_ctrl and pcpm_dp.
//
// Pedal cadence period meter. Each input request is one pedal event: a forward
// step (optionally marking the interval origin), an epoch break with a cause,
// or a measurement clear. Every request yields exactly one result carrying the
// per-step pulse, period and rpm plus a snapshot of the held measurement and
// the wrapping counters. When steps_per_pulse forward steps have been counted
// (a value of 0 behaves as 1) a pulse is reported; with a valid epoch the
// wrapped tick difference, clamped to 64000, is the period, and a period above
// 70 ticks is divided into rpm_numerator to give rpm, saturated to 16 bits.
// Sequencing: a request that needs no division is committed on acceptance; a
// request that produces a measurement is accepted, runs the bit-serial restoring
// divider, one step per numerator bit, and then commits. One request is in
// flight at a time; a new one is taken while the previous result sits in the
// output register, provided that register is empty or being taken in the same
// cycle. The configuration port is always ready; write it only while idle.
// Register index 0 is steps_per_pulse (8 bits), index 1 is rpm_numerator
// (23 bits); writes to other indexes are dropped.
module pedal_cadence_period_meter_unit import pcpm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input requests
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_req                   i_in_req,
    // results
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_result                   o_out_res,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // Always take configuration writes.
    assign o_cfg_ready = 1'b1;

    pcpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    pcpm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in_req),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_res       (o_out_res)
    );

endmodule
